// ===== src/brfr_pkg.sv =====
package brfr_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int CHANNELS_DEF   = 3;

   localparam int CSR_AW = 5;

   localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
   localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
   localparam logic [2:0] REG_INV_SCALE  = 3'd4;

   localparam logic [8:0]  SIZE_RESET  = 9'd256;
   localparam logic [23:0] SCALE_RESET = 24'h010000;

   localparam int PROD_W = 36;
   localparam int TAP_W  = 20;

   typedef struct packed {
      logic       action;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [1:0] channel;
      logic [7:0] sample;
   } brfr_req_type;

   typedef struct packed {
      logic [15:0] pixel_value;
      logic [7:0]  out_x;
      logic [7:0]  out_y;
      logic [1:0]  out_channel;
   } brfr_rsp_type;

   typedef struct packed {
      logic               is_pixel;
      logic               store_ok;
      logic               chan_ok;
      logic signed [10:0] off_x;
      logic signed [10:0] off_y;
      logic [7:0]         pos_x;
      logic [7:0]         pos_y;
      logic [1:0]         channel;
      logic [7:0]         sample;
   } brfr_cmd_type;

   typedef struct packed {
      logic [8:0]  src_width;
      logic [8:0]  src_height;
      logic [8:0]  dst_width;
      logic [8:0]  dst_height;
      logic [23:0] inv_scale;
   } brfr_cfg_type;

endpackage

// ===== src/bilinear_fit_resampler_top.sv =====
// Fit-to-window bilinear resampler.
// Request words arrive on req_item and are taken at a rising edge where start is
// high and busy is low. A load word writes one 8-bit sample of the source image;
// a pixel word asks for one destination pixel and yields exactly one result.
// Each result is shown on rsp_item for one cycle, marked by rsp_valid, once its
// request has passed the queue and the back end. The receiver cannot stall.
// One word is taken every cycle: the four bilinear taps come from four banks of
// the source store, split by row and column parity, which are all read in the
// same cycle. busy rises only if the command queue fills, which a steady stream
// never causes. Load and pixel words are carried out in the order taken.
// The APB port holds the source and destination sizes and the inverse scale;
// write it only while no word is in flight. Reset clears the pipeline and sets
// the registers to their defaults; the source store holds no defined value
// until it is loaded.
module bilinear_fit_resampler_top
   import brfr_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int CHANNELS   = CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  brfr_req_type      req_item,
   output logic              rsp_valid,
   output brfr_rsp_type      rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   brfr_cfg_type cfg_ff;
   brfr_cmd_type front_cmd;
   brfr_cmd_type queue_cmd;
   logic         csr_write;
   logic [2:0]   csr_index;
   logic         queue_full;
   logic         queue_empty;
   logic         push;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[CSR_AW-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= SIZE_RESET;
         cfg_ff.src_height <= SIZE_RESET;
         cfg_ff.dst_width  <= SIZE_RESET;
         cfg_ff.dst_height <= SIZE_RESET;
         cfg_ff.inv_scale  <= SCALE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_SRC_WIDTH: begin
               cfg_ff.src_width <= pwdata[8:0];
            end
            REG_SRC_HEIGHT: begin
               cfg_ff.src_height <= pwdata[8:0];
            end
            REG_DST_WIDTH: begin
               cfg_ff.dst_width <= pwdata[8:0];
            end
            REG_DST_HEIGHT: begin
               cfg_ff.dst_height <= pwdata[8:0];
            end
            REG_INV_SCALE: begin
               cfg_ff.inv_scale <= pwdata[23:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SRC_WIDTH:  prdata = {23'b0, cfg_ff.src_width};
         REG_SRC_HEIGHT: prdata = {23'b0, cfg_ff.src_height};
         REG_DST_WIDTH:  prdata = {23'b0, cfg_ff.dst_width};
         REG_DST_HEIGHT: prdata = {23'b0, cfg_ff.dst_height};
         REG_INV_SCALE:  prdata = {8'b0, cfg_ff.inv_scale};
         default:        prdata = 32'b0;
      endcase
   end

   assign busy = queue_full;
   assign push = start && !queue_full;

   brfr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .CHANNELS   (CHANNELS)
   ) u_front (
      .req_item (req_item),
      .cfg      (cfg_ff),
      .cmd      (front_cmd)
   );

   brfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .full     (queue_full),
      .pop      (!queue_empty),
      .empty    (queue_empty),
      .pop_cmd  (queue_cmd)
   );

   brfr_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .CHANNELS   (CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (!queue_empty),
      .cmd       (queue_cmd),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== src/brfr_ram.sv =====
module brfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/brfr_front.sv =====
module brfr_front
   import brfr_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int CHANNELS   = CHANNELS_DEF
) (
   input  brfr_req_type req_item,
   input  brfr_cfg_type cfg,
   output brfr_cmd_type cmd
);

   always_comb begin
      cmd.is_pixel = req_item.action;
      cmd.store_ok = (32'(req_item.pos_x) < MAX_WIDTH) && (32'(req_item.pos_y) < MAX_HEIGHT)
                     && (32'(req_item.channel) < CHANNELS);
      cmd.chan_ok  = 32'(req_item.channel) < CHANNELS;
      cmd.off_x    = $signed({2'b0, req_item.pos_x, 1'b0}) - $signed({2'b0, cfg.dst_width});
      cmd.off_y    = $signed({2'b0, req_item.pos_y, 1'b0}) - $signed({2'b0, cfg.dst_height});
      cmd.pos_x    = req_item.pos_x;
      cmd.pos_y    = req_item.pos_y;
      cmd.channel  = req_item.channel;
      cmd.sample   = req_item.sample;
   end

endmodule

// ===== src/brfr_queue.sv =====
module brfr_queue
   import brfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  brfr_cmd_type push_cmd,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output brfr_cmd_type pop_cmd
);

   brfr_cmd_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("Word pushed into a full queue.");
   assert property (@(posedge clock) disable iff (reset) empty |-> !pop)
      else $error("Word popped from an empty queue.");

endmodule

// ===== src/brfr_back.sv =====
module brfr_back
   import brfr_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int CHANNELS   = CHANNELS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  brfr_cfg_type cfg,
   input  logic         cmd_valid,
   input  brfr_cmd_type cmd,
   output logic         rsp_valid,
   output brfr_rsp_type rsp_item
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int XHB   = (XW > 1) ? XW - 1 : 1;
   localparam int YHB   = (YW > 1) ? YW - 1 : 1;
   localparam int CB    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int AW    = CB + YHB + XHB;
   localparam int DEPTH = 2 ** AW;

   function automatic logic [8:0] clamp_tap(input logic signed [TAP_W-1:0] t,
                                             input logic [8:0] size);
      logic signed [TAP_W-1:0] last;
      last = $signed({{(TAP_W-9){1'b0}}, size}) - TAP_W'(1);
      if (t < 0) begin
         clamp_tap = 9'd0;
      end else if (t > last) begin
         clamp_tap = last[8:0];
      end else begin
         clamp_tap = t[8:0];
      end
   endfunction

   logic [8:0] sw;
   logic [8:0] sh;

   always_comb begin
      sw = cfg.src_width;
      if (cfg.src_width == 9'd0) begin
         sw = 9'd1;
      end else if (32'(cfg.src_width) > MAX_WIDTH) begin
         sw = 9'(MAX_WIDTH);
      end
      sh = cfg.src_height;
      if (cfg.src_height == 9'd0) begin
         sh = 9'd1;
      end else if (32'(cfg.src_height) > MAX_HEIGHT) begin
         sh = 9'(MAX_HEIGHT);
      end
   end

   // Stage 1: scale the centered offsets.
   logic signed [PROD_W-1:0] px_in;
   logic signed [PROD_W-1:0] py_in;
   logic                     s1_valid_ff;
   brfr_cmd_type             s1_cmd_ff;
   logic signed [PROD_W-1:0] s1_px_ff;
   logic signed [PROD_W-1:0] s1_py_ff;

   assign px_in = cmd.off_x * $signed({1'b0, cfg.inv_scale});
   assign py_in = cmd.off_y * $signed({1'b0, cfg.inv_scale});

   // Stage 2: add the source center and split into tap and fraction.
   logic signed [PROD_W-1:0] twice_x;
   logic signed [PROD_W-1:0] twice_y;
   logic                     s2_valid_ff;
   brfr_cmd_type             s2_cmd_ff;
   logic signed [TAP_W-1:0]  s2_ix_ff;
   logic signed [TAP_W-1:0]  s2_iy_ff;
   logic [15:0]              s2_fx_ff;
   logic [15:0]              s2_fy_ff;

   assign twice_x = s1_px_ff + $signed({11'b0, sw, 16'b0});
   assign twice_y = s1_py_ff + $signed({11'b0, sh, 16'b0});

   // Stage 3: clamp the taps and address the four banks.
   logic [XW-1:0]  x0;
   logic [XW-1:0]  x1;
   logic [YW-1:0]  y0;
   logic [YW-1:0]  y1;
   logic [3:0]     wr_en;
   logic [3:0]     rd_en;
   logic [AW-1:0]  wr_addr;
   logic [AW-1:0]  rd_addr [4];
   logic [7:0]     rd_data [4];
   logic           s3_valid_ff;
   brfr_cmd_type   s3_cmd_ff;
   logic [1:0]     s3_tap00_ff;
   logic [1:0]     s3_tap01_ff;
   logic [1:0]     s3_tap10_ff;
   logic [1:0]     s3_tap11_ff;
   logic [15:0]    s3_fx_ff;
   logic [15:0]    s3_fy_ff;

   assign x0 = XW'(clamp_tap(s2_ix_ff, sw));
   assign x1 = XW'(clamp_tap(s2_ix_ff + TAP_W'(1), sw));
   assign y0 = YW'(clamp_tap(s2_iy_ff, sh));
   assign y1 = YW'(clamp_tap(s2_iy_ff + TAP_W'(1), sh));

   assign wr_addr = {s2_cmd_ff.channel[CB-1:0], YHB'(s2_cmd_ff.pos_y >> 1),
                     XHB'(s2_cmd_ff.pos_x >> 1)};

   generate
      for (genvar b = 0; b < 4; b++) begin : g_bank
         logic [XHB-1:0] col;
         logic [YHB-1:0] row;

         assign col = (x0[0] == 1'(b % 2)) ? XHB'(x0 >> 1) : XHB'(x1 >> 1);
         assign row = (y0[0] == 1'(b / 2)) ? YHB'(y0 >> 1) : YHB'(y1 >> 1);
         assign rd_addr[b] = {s2_cmd_ff.channel[CB-1:0], row, col};
         assign wr_en[b] = s2_valid_ff && !s2_cmd_ff.is_pixel && s2_cmd_ff.store_ok
                           && ({s2_cmd_ff.pos_y[0], s2_cmd_ff.pos_x[0]} == 2'(b));
         assign rd_en[b] = s2_valid_ff && s2_cmd_ff.is_pixel && s2_cmd_ff.chan_ok;

         brfr_ram #(
            .WIDTH (8),
            .DEPTH (DEPTH)
         ) u_ram (
            .clock   (clock),
            .wr_en   (wr_en[b]),
            .wr_addr (wr_addr),
            .wr_data (s2_cmd_ff.sample),
            .rd_en   (rd_en[b]),
            .rd_addr (rd_addr[b]),
            .rd_data (rd_data[b])
         );
      end
   endgenerate

   // Stage 4: blend along x.
   logic [16:0]  gx;
   logic [24:0]  h0_sum;
   logic [24:0]  h1_sum;
   logic         s4_valid_ff;
   brfr_cmd_type s4_cmd_ff;
   logic [23:0]  s4_h0_ff;
   logic [23:0]  s4_h1_ff;
   logic [16:0]  s4_gy_ff;
   logic [15:0]  s4_fy_ff;

   assign gx     = 17'h10000 - {1'b0, s3_fx_ff};
   assign h0_sum = rd_data[s3_tap00_ff] * gx + rd_data[s3_tap01_ff] * {1'b0, s3_fx_ff};
   assign h1_sum = rd_data[s3_tap10_ff] * gx + rd_data[s3_tap11_ff] * {1'b0, s3_fx_ff};

   // Stage 5: blend along y into the result register.
   logic [40:0]  acc;
   logic         rsp_valid_ff;
   brfr_rsp_type rsp_item_ff;

   assign acc = s4_h0_ff * s4_gy_ff + s4_h1_ff * {1'b0, s4_fy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff && s2_cmd_ff.is_pixel;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff   <= cmd;
      s1_px_ff    <= px_in;
      s1_py_ff    <= py_in;
      s2_cmd_ff   <= s1_cmd_ff;
      s2_ix_ff    <= {twice_x[PROD_W-1], twice_x[PROD_W-1:17]};
      s2_iy_ff    <= {twice_y[PROD_W-1], twice_y[PROD_W-1:17]};
      s2_fx_ff    <= twice_x[16:1];
      s2_fy_ff    <= twice_y[16:1];
      s3_cmd_ff   <= s2_cmd_ff;
      s3_tap00_ff <= {y0[0], x0[0]};
      s3_tap01_ff <= {y0[0], x1[0]};
      s3_tap10_ff <= {y1[0], x0[0]};
      s3_tap11_ff <= {y1[0], x1[0]};
      s3_fx_ff    <= s2_fx_ff;
      s3_fy_ff    <= s2_fy_ff;
      s4_cmd_ff   <= s3_cmd_ff;
      s4_h0_ff    <= h0_sum[23:0];
      s4_h1_ff    <= h1_sum[23:0];
      s4_gy_ff    <= 17'h10000 - {1'b0, s3_fy_ff};
      s4_fy_ff    <= s3_fy_ff;
      rsp_item_ff.pixel_value <= s4_cmd_ff.chan_ok ? acc[39:24] : 16'd0;
      rsp_item_ff.out_x       <= s4_cmd_ff.pos_x;
      rsp_item_ff.out_y       <= s4_cmd_ff.pos_y;
      rsp_item_ff.out_channel <= s4_cmd_ff.channel;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |-> $past(s3_valid_ff, 2))
      else $error("Result word without a pixel request two stages back.");
   assert property (@(posedge clock) disable iff (reset) !((|wr_en) && (|rd_en)))
      else $error("Store written and read in the same cycle.");
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_cmd_ff.is_pixel) |-> ((32'(x1) < 32'(sw)) && (32'(y1) < 32'(sh))))
      else $error("Clamped tap lies outside the source image.");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   import brfr_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LATENCY        = 5;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   brfr_req_type      req_item;
   logic              rsp_valid;
   brfr_rsp_type      rsp_item;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   brfr_req_type pending_words[$];
   brfr_rsp_type expected_pixels[$];

   logic [7:0]  image_model [0:CHANNELS_DEF-1][0:MAX_HEIGHT_DEF-1][0:MAX_WIDTH_DEF-1];
   bit          filled [0:CHANNELS_DEF-1][0:MAX_HEIGHT_DEF-1][0:MAX_WIDTH_DEF-1];
   logic [8:0]  model_src_width;
   logic [8:0]  model_src_height;
   logic [8:0]  model_dst_width;
   logic [8:0]  model_dst_height;
   logic [23:0] model_inv_scale;

   int  idle_pct;
   int  fail_count;
   int  quiet_cycles;
   logic word_taken;

   bilinear_fit_resampler_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic int unsigned clamp_size(logic [8:0] v);
      if (v == 9'd0) return 1;
      if (v > 9'd256) return 256;
      return v;
   endfunction

   function automatic int unsigned clamp_tap(longint t, int unsigned size);
      if (t < 0) return 0;
      if (t > longint'(size) - 1) return size - 1;
      return int'(t);
   endfunction

   function automatic longint source_coord(logic [7:0] pos, logic [8:0] dsize,
                                           int unsigned ssize);
      longint twice;
      twice = (2 * longint'(pos) - longint'(dsize)) * longint'(model_inv_scale)
              + longint'(ssize) * 65536;
      return twice >>> 1;
   endfunction

   function automatic brfr_rsp_type interpolate_pixel(brfr_req_type w);
      brfr_rsp_type     r;
      int unsigned      sw, sh, x0, x1, y0, y1;
      longint           cx, cy, ix, iy;
      longint unsigned  fx, fy, gx, gy, acc;
      r.out_x       = w.pos_x;
      r.out_y       = w.pos_y;
      r.out_channel = w.channel;
      r.pixel_value = 16'd0;
      if (w.channel < CHANNELS_DEF) begin
         sw = clamp_size(model_src_width);
         sh = clamp_size(model_src_height);
         cx = source_coord(w.pos_x, model_dst_width, sw);
         cy = source_coord(w.pos_y, model_dst_height, sh);
         ix = cx >>> 16;
         iy = cy >>> 16;
         fx = longint'(cx - ix * 65536);
         fy = longint'(cy - iy * 65536);
         gx = 65536 - fx;
         gy = 65536 - fy;
         x0 = clamp_tap(ix, sw);
         x1 = clamp_tap(ix + 1, sw);
         y0 = clamp_tap(iy, sh);
         y1 = clamp_tap(iy + 1, sh);
         acc = longint'(image_model[w.channel][y0][x0]) * gx * gy
             + longint'(image_model[w.channel][y0][x1]) * fx * gy
             + longint'(image_model[w.channel][y1][x0]) * gx * fy
             + longint'(image_model[w.channel][y1][x1]) * fx * fy;
         r.pixel_value = acc[39:24];
      end
      return r;
   endfunction

   // Driver: a word is held until taken, then the next one is offered.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !word_taken) begin
         start <= 1'b1;
      end else if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
         req_item <= pending_words.pop_front();
         start    <= 1'b1;
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor, predictor and watchdog.
   always @(posedge clock) begin
      brfr_rsp_type exp_px;
      if (reset) begin
         word_taken   <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         word_taken <= start && !busy;
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_AW-1:2])
               REG_SRC_WIDTH:  model_src_width  = pwdata[8:0];
               REG_SRC_HEIGHT: model_src_height = pwdata[8:0];
               REG_DST_WIDTH:  model_dst_width  = pwdata[8:0];
               REG_DST_HEIGHT: model_dst_height = pwdata[8:0];
               REG_INV_SCALE:  model_inv_scale  = pwdata[23:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_item.action) begin
               expected_pixels.push_back(interpolate_pixel(req_item));
            end else if (req_item.channel < CHANNELS_DEF) begin
               image_model[req_item.channel][req_item.pos_y][req_item.pos_x] =
                  req_item.sample;
            end
         end
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result word x=%0d y=%0d", rsp_item.out_x, rsp_item.out_y);
               fail_count++;
            end else begin
               exp_px = expected_pixels.pop_front();
               if (rsp_item.pixel_value !== exp_px.pixel_value) begin
                  $error("pixel_value expected %0h actual %0h",
                         exp_px.pixel_value, rsp_item.pixel_value);
                  fail_count++;
               end
               if (rsp_item.out_x !== exp_px.out_x) begin
                  $error("out_x expected %0d actual %0d", exp_px.out_x, rsp_item.out_x);
                  fail_count++;
               end
               if (rsp_item.out_y !== exp_px.out_y) begin
                  $error("out_y expected %0d actual %0d", exp_px.out_y, rsp_item.out_y);
                  fail_count++;
               end
               if (rsp_item.out_channel !== exp_px.out_channel) begin
                  $error("out_channel expected %0d actual %0d",
                         exp_px.out_channel, rsp_item.out_channel);
                  fail_count++;
               end
            end
         end
      end
   end

   task automatic queue_word(logic action, logic [7:0] x, logic [7:0] y,
                             logic [1:0] c, logic [7:0] s);
      brfr_req_type w;
      w.action  = action;
      w.pos_x   = x;
      w.pos_y   = y;
      w.channel = c;
      w.sample  = s;
      pending_words.push_back(w);
   endtask

   task automatic drain;
      while (pending_words.size() > 0 || start || expected_pixels.size() > 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 3) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Waits until all words are through, then writes all registers and loads the part
   // of the visible source region of the first chans channels that has not been loaded yet.
   task automatic set_geometry(logic [8:0] sw, logic [8:0] sh, logic [8:0] dw,
                               logic [8:0] dh, logic [23:0] scale, int unsigned chans,
                               output int unsigned csw, output int unsigned csh);
      drain();
      csr_write(REG_SRC_WIDTH, {23'd0, sw});
      csr_write(REG_SRC_HEIGHT, {23'd0, sh});
      csr_write(REG_DST_WIDTH, {23'd0, dw});
      csr_write(REG_DST_HEIGHT, {23'd0, dh});
      csr_write(REG_INV_SCALE, {8'd0, scale});
      csw = clamp_size(sw);
      csh = clamp_size(sh);
      for (int c = 0; c < chans; c++) begin
         for (int y = 0; y < csh; y++) begin
            for (int x = 0; x < csw; x++) begin
               if (!filled[c][y][x]) begin
                  filled[c][y][x] = 1'b1;
                  queue_word(1'b0, 8'(x), 8'(y), 2'(c), 8'($urandom_range(255)));
               end
            end
         end
      end
   endtask

   initial begin
      int unsigned csw, csh;
      logic [23:0] scale;
      reset      = 1'b1;
      start      = 1'b0;
      req_item   = '0;
      psel       = 1'b0;
      penable    = 1'b0;
      pwrite     = 1'b0;
      paddr      = '0;
      pwdata     = '0;
      idle_pct   = 12;
      fail_count = 0;
      model_src_width  = SIZE_RESET;
      model_src_height = SIZE_RESET;
      model_dst_width  = SIZE_RESET;
      model_dst_height = SIZE_RESET;
      model_inv_scale  = SCALE_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_geometry(9'd4, 9'd4, 9'd8, 9'd8, 24'h008000, CHANNELS_DEF, csw, csh);
      queue_word(1'b1, 8'd0, 8'd0, 2'd0, 8'd0);
      queue_word(1'b1, 8'd255, 8'd255, 2'd1, 8'd255);
      queue_word(1'b1, 8'd7, 8'd7, 2'd2, 8'd0);
      queue_word(1'b1, 8'd3, 8'd0, 2'd3, 8'd0);
      queue_word(1'b1, 8'd0, 8'd255, 2'd0, 8'd0);
      queue_word(1'b0, 8'd1, 8'd1, 2'd3, 8'd255);
      queue_word(1'b1, 8'd3, 8'd3, 2'd0, 8'd0);
      queue_word(1'b0, 8'd2, 8'd2, 2'd1, 8'd255);
      queue_word(1'b0, 8'd1, 8'd3, 2'd1, 8'd0);
      queue_word(1'b1, 8'd4, 8'd5, 2'd1, 8'd0);
      queue_word(1'b0, 8'd255, 8'd255, 2'd0, 8'd255);
      queue_word(1'b1, 8'd4, 8'd4, 2'd0, 8'd0);
      set_geometry(9'd256, 9'd1, 9'd256, 9'd1, 24'h010000, 1, csw, csh);
      for (int i = 0; i < 8; i++) begin
         queue_word(1'b1, 8'(i * 36), 8'd0, (i % 3 == 2) ? 2'd3 : 2'd0, 8'd0);
      end
      set_geometry(9'd1, 9'd256, 9'd1, 9'd256, 24'h010000, 1, csw, csh);
      for (int i = 0; i < 8; i++) begin
         queue_word(1'b1, 8'd0, 8'(255 - i * 36), (i % 3 == 2) ? 2'd3 : 2'd0, 8'd0);
      end
      set_geometry(9'd0, 9'd511, 9'd0, 9'd511, 24'hFFFFFF, 1, csw, csh);
      queue_word(1'b1, 8'd0, 8'd128, 2'd0, 8'd0);
      queue_word(1'b1, 8'd255, 8'd0, 2'd0, 8'd0);

      for (int ph = 0; ph < 12; ph++) begin
         idle_pct = (ph < 4) ? 12 : (ph < 8) ? 56 : 0;
         case ($urandom_range(2))
            0: scale = 24'($urandom_range(24'hFFFFFF));
            1: scale = 24'(24'h010000 * $urandom_range(1, 4));
            default: scale = 24'($urandom_range(24'h01FFFF, 24'h008000));
         endcase
         set_geometry(9'($urandom_range(1, 8)), 9'($urandom_range(1, 8)),
                      9'($urandom_range(511)), 9'($urandom_range(511)), scale,
                      CHANNELS_DEF, csw, csh);
         for (int i = 0; i < 50; i++) begin
            if ($urandom_range(99) < 75) begin
               queue_word(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2)),
                          8'($urandom_range(255)));
            end else if ($urandom_range(1)) begin
               queue_word(1'b0, 8'($urandom_range(csw - 1)), 8'($urandom_range(csh - 1)),
                          2'($urandom_range(2)), 8'($urandom_range(255)));
            end else begin
               queue_word(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          2'($urandom_range(3)), 8'($urandom_range(255)));
            end
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
